// File: src/wsd_pkg.sv
// Package for the WebSocket frame deframer: phase codes, result kinds,
// header constants and the result record type. No dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

    // Parse phase codes
    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    // Header field constants
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] OP_BINARY  = 4'h2;
    localparam logic [3:0] OP_CLOSE   = 4'h8;

    // Header byte counter end values (count of the last byte, from zero)
    localparam logic [2:0] CNT_LAST_EXT16 = 3'd1;
    localparam logic [2:0] CNT_LAST_EXT64 = 3'd7;
    localparam logic [2:0] CNT_LAST_KEY   = 3'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [3:0]  frame_opcode;
        logic [63:0] payload_length;
        logic        was_masked;
        logic        last;
    } t_result;

endpackage

// File: src/websocket_frame_deframer.sv
// WebSocket frame deframer top level. Throughput: one byte per cycle while
// the skid register is empty. Each result is registered, in the output
// register or the skid register. The output register plus a one-entry skid
// register let input continue while a result waits. Reset (i_rst_n low,
// synchronous) clears the parse state to expect a first header byte and
// empties the output. Depends on wsd_pkg.
`timescale 1ns / 1ps

module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [3:0]  o_frame_opcode,
    output logic [63:0] o_payload_length,
    output logic        o_was_masked,
    output logic        o_last
);
    import wsd_pkg::*;

    // Parse state
    logic [2:0]  r_phase,      n_phase;
    logic [2:0]  r_hdr_cnt,    n_hdr_cnt;
    logic [63:0] r_len_acc,    n_len_acc;
    logic        r_ext_long,   n_ext_long;
    logic [31:0] r_mask_key,   n_mask_key;
    logic        r_mask_on,    n_mask_on;
    logic [3:0]  r_opcode,     n_opcode;
    logic [63:0] r_remaining,  n_remaining;
    logic [1:0]  r_key_index,  n_key_index;

    // Output register and skid register
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic        in_accept;
    logic        out_take;
    logic        res_valid;
    t_result     res;
    logic        hdr_fire;
    logic [63:0] hdr_len;
    logic        hdr_masked;
    logic        len_fire;
    logic [63:0] len_val;
    logic        len_masked;
    logic [6:0]  len7;
    logic [2:0]  rsv;
    logic [3:0]  op;
    logic [7:0]  key_byte;
    logic        pay_last;

    assign o_in_ready = !r_skid_valid;
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_take   = r_out_valid && i_out_ready;

    assign len7     = i_in_byte[6:0];
    assign rsv      = i_in_byte[6:4];
    assign op       = i_in_byte[3:0];
    assign key_byte = r_mask_key[{~r_key_index, 3'b000} +: 8];
    assign pay_last = (r_remaining == 64'd1);

    // Next parse state and result for the byte at the input
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_len_acc   = r_len_acc;
        n_ext_long  = r_ext_long;
        n_mask_key  = r_mask_key;
        n_mask_on   = r_mask_on;
        n_opcode    = r_opcode;
        n_remaining = r_remaining;
        n_key_index = r_key_index;
        res_valid   = 1'b0;
        res         = '0;
        len_fire    = 1'b0;
        len_val     = r_len_acc;
        len_masked  = r_mask_on;
        hdr_fire    = 1'b0;
        hdr_len     = r_len_acc;
        hdr_masked  = r_mask_on;

        case (r_phase)
            PH_ERROR: begin
                n_phase = PH_ERROR;
            end
            PH_SECOND: begin
                n_mask_on = i_in_byte[7];
                n_hdr_cnt = 3'd0;
                if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
                    n_ext_long = (len7 == LEN7_EXT64);
                    n_len_acc  = 64'd0;
                    n_phase    = PH_EXTLEN;
                end else begin
                    n_len_acc  = {57'd0, len7};
                    len_fire   = 1'b1;
                    len_val    = {57'd0, len7};
                    len_masked = i_in_byte[7];
                end
            end
            PH_EXTLEN: begin
                n_len_acc = {r_len_acc[55:0], i_in_byte};
                if (r_hdr_cnt == (r_ext_long ? CNT_LAST_EXT64 : CNT_LAST_EXT16)) begin
                    len_fire   = 1'b1;
                    len_val    = {r_len_acc[55:0], i_in_byte};
                    len_masked = r_mask_on;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                end
            end
            PH_KEY: begin
                n_mask_key = {r_mask_key[23:0], i_in_byte};
                if (r_hdr_cnt == CNT_LAST_KEY) begin
                    hdr_fire   = 1'b1;
                    hdr_len    = r_len_acc;
                    hdr_masked = r_mask_on;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                n_key_index          = r_key_index + 2'd1;
                n_remaining          = r_remaining - 64'd1;
                if (pay_last) begin
                    n_phase = PH_FIRST;
                end
                res_valid            = 1'b1;
                res.kind             = KIND_PAY;
                res.data             = r_mask_on ? (i_in_byte ^ key_byte) : i_in_byte;
                res.frame_opcode     = r_opcode;
                res.payload_length   = 64'd0;
                res.was_masked       = r_mask_on;
                res.last             = pay_last;
            end
            default: begin
                // First header byte: FIN, RSV and opcode checks
                if (!i_in_byte[7] || rsv != 3'd0 || (op != OP_BINARY && op != OP_CLOSE)) begin
                    n_phase          = PH_ERROR;
                    res_valid        = 1'b1;
                    res.kind         = KIND_ERR;
                    res.frame_opcode = op;
                end else begin
                    n_opcode  = op;
                    n_mask_on = 1'b0;
                    n_phase   = PH_SECOND;
                end
            end
        endcase

        // Length known: go to the key or finish the header
        if (len_fire) begin
            n_hdr_cnt = 3'd0;
            if (len_masked) begin
                n_mask_key = 32'd0;
                n_phase    = PH_KEY;
            end else begin
                hdr_fire   = 1'b1;
                hdr_len    = len_val;
                hdr_masked = 1'b0;
            end
        end

        // Header complete
        if (hdr_fire) begin
            n_remaining        = hdr_len;
            n_key_index        = 2'd0;
            n_hdr_cnt          = 3'd0;
            n_phase            = (hdr_len != 64'd0) ? PH_PAYLOAD : PH_FIRST;
            res_valid          = 1'b1;
            res.kind           = KIND_HDR;
            res.data           = 8'd0;
            res.frame_opcode   = r_opcode;
            res.payload_length = hdr_len;
            res.was_masked     = hdr_masked;
            res.last           = (hdr_len == 64'd0);
        end
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_hdr_cnt   <= 3'd0;
            r_len_acc   <= 64'd0;
            r_ext_long  <= 1'b0;
            r_mask_key  <= 32'd0;
            r_mask_on   <= 1'b0;
            r_opcode    <= 4'd0;
            r_remaining <= 64'd0;
            r_key_index <= 2'd0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_len_acc   <= n_len_acc;
            r_ext_long  <= n_ext_long;
            r_mask_key  <= n_mask_key;
            r_mask_on   <= n_mask_on;
            r_opcode    <= n_opcode;
            r_remaining <= n_remaining;
            r_key_index <= n_key_index;
        end
    end

    // Output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= in_accept && res_valid;
            end else begin
                r_out_valid  <= in_accept && res_valid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end else if (in_accept && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_data           = r_out.data;
    assign o_frame_opcode   = r_out.frame_opcode;
    assign o_payload_length = r_out.payload_length;
    assign o_was_masked     = r_out.was_masked;
    assign o_last           = r_out.last;

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ERROR |=> r_phase == PH_ERROR)
        else $error("left the error phase without reset");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remaining != 64'd0)
        else $error("payload phase with no bytes remaining");

    a_pay_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_PAY) |-> o_payload_length == 64'd0)
        else $error("payload result carries a length");

endmodule
